>>> src/oas_pkg.sv
`timescale 1ns / 1ps

package oas_pkg;

  // command codes of the input beat
  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_REMOVE = 3'd4,
    CMD_FIND   = 3'd5,
    CMD_READ   = 3'd6,
    CMD_UPDATE = 3'd7
  } cmd_e;

  // status codes of the result beat
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_RANGE  = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_FULL   = 3'd3,
    ST_ABSENT = 3'd4
  } status_e;

  // memory port controls from the sequencer to the datapath
  typedef struct packed {
    logic we;
    logic re;
    logic wsel_word;
  } mem_ctl_t;

  // one finished result
  typedef struct packed {
    logic        valid;
    status_e     status;
    logic [31:0] answer;
    logic [6:0]  fill;
  } result_t;

endpackage

>>> src/oas_dp.sv
`timescale 1ns / 1ps

module oas_dp #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  oas_pkg::mem_ctl_t  ctl_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic [AW-1:0]      raddr_i,
  input  logic [31:0]        word_i,
  output logic [31:0]        rdata_o,
  output logic               match_o
);

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rdata_q;
  logic [31:0] wdata;

  // write data is either the command word or the element just read
  assign wdata = ctl_i.wsel_word ? word_i : rdata_q;

  // element store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata;
    end
    if (ctl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // shared compare unit
  assign match_o = (rdata_q == word_i);
  assign rdata_o = rdata_q;

endmodule

>>> src/oas_seq.sv
`timescale 1ns / 1ps

module oas_seq #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [2:0]         cmd_i,
  input  logic [5:0]         position_i,
  input  logic [31:0]        word_i,
  output logic               busy_o,
  output oas_pkg::mem_ctl_t  ctl_o,
  output logic [AW-1:0]      waddr_o,
  output logic [AW-1:0]      raddr_o,
  output logic [31:0]        word_o,
  input  logic [31:0]        rdata_i,
  input  logic               match_i,
  output oas_pkg::result_t   result_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_RDWAIT = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  oas_pkg::cmd_e      cmd_q;
  logic [5:0]         pos_q;
  logic [31:0]        word_q;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      left_q, left_d;
  logic [CW-1:0]      rd_q, rd_d;
  logic [CW-1:0]      pa_q, pa_d;
  logic [CW-1:0]      wp_q, wp_d;
  logic               pend_q, pend_d;

  logic [31:0]        n_ext;
  logic [31:0]        pos_ext;
  logic [31:0]        cnt_ext;
  logic [CW-1:0]      pos_cw;
  logic [CW-1:0]      pa_up;
  logic [CW-1:0]      pa_dn;
  logic               pos_ok;
  logic               full;
  logic               more;

  assign n_ext   = 32'(count_q);
  assign pos_ext = 32'(pos_q);
  assign pos_cw  = pos_ext[CW-1:0];
  assign pos_ok  = pos_ext < n_ext;
  assign full    = n_ext >= 32'(DEPTH);
  assign more    = (left_q != '0);
  assign pa_up   = pa_q + CW'(1);
  assign pa_dn   = pa_q - CW'(1);

  // command beat capture and walk pointer registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      cmd_q  <= oas_pkg::cmd_e'(cmd_i);
      pos_q  <= position_i;
      word_q <= word_i;
    end
    rd_q <= rd_d;
    pa_q <= pa_d;
    wp_q <= wp_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      left_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      left_q  <= left_d;
      pend_q  <= pend_d;
    end
  end

  // sequencer: decode, element walk and result
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    left_d   = left_q;
    rd_d     = rd_q;
    pa_d     = pa_q;
    wp_d     = wp_q;
    pend_d   = 1'b0;
    ctl_o    = '0;
    waddr_o  = '0;
    raddr_o  = rd_q[AW-1:0];
    result_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        // default: finish now with ok
        state_d         = S_IDLE;
        result_o.valid  = 1'b1;
        result_o.status = oas_pkg::ST_OK;
        unique case (cmd_q)
          oas_pkg::CMD_PUSH: begin
            if (full) begin
              result_o.status = oas_pkg::ST_FULL;
              result_o.answer = n_ext;
            end else begin
              ctl_o.we        = 1'b1;
              ctl_o.wsel_word = 1'b1;
              waddr_o         = count_q[AW-1:0];
              count_d         = count_q + CW'(1);
            end
          end
          oas_pkg::CMD_POP: begin
            if (count_q == '0) begin
              result_o.status = oas_pkg::ST_EMPTY;
              result_o.answer = n_ext;
            end else begin
              count_d = count_q - CW'(1);
            end
          end
          oas_pkg::CMD_INSERT: begin
            if (!pos_ok) begin
              result_o.status = oas_pkg::ST_RANGE;
              result_o.answer = n_ext;
            end else if (full) begin
              result_o.status = oas_pkg::ST_FULL;
              result_o.answer = n_ext;
            end else begin
              result_o.valid = 1'b0;
              state_d        = S_SCAN;
              rd_d           = count_q - CW'(1);
              left_d         = count_q - pos_cw;
            end
          end
          oas_pkg::CMD_DELETE: begin
            if (count_q == '0) begin
              result_o.status = oas_pkg::ST_EMPTY;
              result_o.answer = n_ext;
            end else if (!pos_ok) begin
              result_o.status = oas_pkg::ST_RANGE;
              result_o.answer = n_ext;
            end else begin
              result_o.valid = 1'b0;
              state_d        = S_SCAN;
              rd_d           = pos_cw + CW'(1);
              left_d         = count_q - pos_cw - CW'(1);
            end
          end
          oas_pkg::CMD_REMOVE, oas_pkg::CMD_FIND: begin
            result_o.valid = 1'b0;
            state_d        = S_SCAN;
            rd_d           = '0;
            wp_d           = '0;
            left_d         = count_q;
          end
          oas_pkg::CMD_READ: begin
            if (!pos_ok) begin
              result_o.status = oas_pkg::ST_RANGE;
              result_o.answer = n_ext;
            end else begin
              result_o.valid = 1'b0;
              state_d        = S_RDWAIT;
              ctl_o.re       = 1'b1;
              raddr_o        = pos_ext[AW-1:0];
            end
          end
          oas_pkg::CMD_UPDATE: begin
            if (!pos_ok) begin
              result_o.status = oas_pkg::ST_RANGE;
              result_o.answer = n_ext;
            end else begin
              ctl_o.we        = 1'b1;
              ctl_o.wsel_word = 1'b1;
              waddr_o         = pos_ext[AW-1:0];
            end
          end
        endcase
      end

      S_SCAN: begin
        // issue the next element read
        if (more) begin
          ctl_o.re = 1'b1;
          pend_d   = 1'b1;
          pa_d     = rd_q;
          left_d   = left_q - CW'(1);
          rd_d     = (cmd_q == oas_pkg::CMD_INSERT) ? rd_q - CW'(1) : rd_q + CW'(1);
        end
        if (pend_q) begin
          // handle the element read in the last cycle
          unique case (cmd_q)
            oas_pkg::CMD_INSERT: begin
              ctl_o.we = 1'b1;
              waddr_o  = pa_up[AW-1:0];
            end
            oas_pkg::CMD_DELETE: begin
              ctl_o.we = 1'b1;
              waddr_o  = pa_dn[AW-1:0];
            end
            oas_pkg::CMD_REMOVE: begin
              if (!match_i) begin
                ctl_o.we = 1'b1;
                waddr_o  = wp_q[AW-1:0];
                wp_d     = wp_q + CW'(1);
              end
            end
            oas_pkg::CMD_FIND: begin
              if (match_i) begin
                state_d         = S_IDLE;
                pend_d          = 1'b0;
                left_d          = '0;
                result_o.valid  = 1'b1;
                result_o.status = oas_pkg::ST_OK;
                result_o.answer = 32'(pa_q);
              end
            end
            default: ;
          endcase
        end else if (!more) begin
          // walk done: close out the command
          state_d        = S_IDLE;
          result_o.valid = 1'b1;
          unique case (cmd_q)
            oas_pkg::CMD_INSERT: begin
              ctl_o.we        = 1'b1;
              ctl_o.wsel_word = 1'b1;
              waddr_o         = pos_ext[AW-1:0];
              count_d         = count_q + CW'(1);
              result_o.status = oas_pkg::ST_OK;
            end
            oas_pkg::CMD_DELETE: begin
              count_d         = count_q - CW'(1);
              result_o.status = oas_pkg::ST_OK;
            end
            oas_pkg::CMD_REMOVE: begin
              if (wp_q == count_q) begin
                result_o.status = oas_pkg::ST_ABSENT;
                result_o.answer = n_ext;
              end else begin
                count_d         = wp_q;
                result_o.status = oas_pkg::ST_OK;
              end
            end
            default: begin
              result_o.status = oas_pkg::ST_ABSENT;
              result_o.answer = n_ext;
            end
          endcase
        end
      end

      S_RDWAIT: begin
        state_d         = S_IDLE;
        result_o.valid  = 1'b1;
        result_o.status = oas_pkg::ST_OK;
        result_o.answer = rdata_i;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    cnt_ext       = 32'(count_d);
    result_o.fill = cnt_ext[6:0];
  end

  assign busy_o = (state_q != S_IDLE);
  assign word_o = word_q;

endmodule

>>> src/ordered_array_store.sv
`timescale 1ns / 1ps

// Ordered store of up to DEPTH signed 32-bit words with a fill count. A command
// beat is taken when start is high and busy is low; busy then stays high until
// the single result beat, which is marked by done_o for one cycle, in the first
// cycle busy is low again; status_o/answer_o/fill_count_o hold it until the next
// result. The receiver cannot stall: done_o is a one-cycle strobe. Push, pop,
// update and every rejected command finish in the execute state; read adds a
// wait state for the registered memory read. Insert, delete, remove and find walk
// the stored elements through the single read port of the element memory, one
// element a cycle: insert walks count - position, delete count - position - 1,
// remove all count elements, find up to and including the first match. The
// longest walk is a remove, or a find with no match, over a full store. The
// element memory needs no clearing after reset; only the fill count and the
// control state are reset.
module ordered_array_store #(
  parameter int DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         cmd_i,
  input  logic [5:0]         position_i,
  input  logic signed [31:0] word_i,
  output logic               done_o,
  output logic [2:0]         status_o,
  output logic signed [31:0] answer_o,
  output logic [6:0]         fill_count_o
);

  localparam int AW = $clog2(DEPTH);

  oas_pkg::mem_ctl_t ctl;
  oas_pkg::result_t  res;
  oas_pkg::result_t  res_q;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [31:0]       word_q;
  logic [31:0]       rdata;
  logic              match;
  logic              done_q;

  oas_seq #(
    .DEPTH(DEPTH)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .cmd_i      (cmd_i),
    .position_i (position_i),
    .word_i     ($unsigned(word_i)),
    .busy_o     (busy),
    .ctl_o      (ctl),
    .waddr_o    (waddr),
    .raddr_o    (raddr),
    .word_o     (word_q),
    .rdata_i    (rdata),
    .match_i    (match),
    .result_o   (res)
  );

  oas_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .waddr_i (waddr),
    .raddr_i (raddr),
    .word_i  (word_q),
    .rdata_o (rdata),
    .match_o (match)
  );

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= res.valid;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      res_q <= res;
    end
  end

  assign done_o       = done_q;
  assign status_o     = res_q.status;
  assign answer_o     = $signed(res_q.answer);
  assign fill_count_o = res_q.fill;

endmodule

>>> src/oas_checker.sv
`timescale 1ns / 1ps

module oas_checker #(
  parameter int DEPTH = 64
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_i,
  input logic [2:0]         status_i,
  input logic signed [31:0] answer_i,
  input logic [6:0]         fill_count_i
);

  // a result beat only shows once the command has finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> !busy)
    else $error("result beat while busy");

  // an accepted command always makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // every command that ends delivers its result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_i)
    else $error("command ended without a result beat");

  // a rejected command reports the unchanged count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && status_i != oas_pkg::ST_OK) |-> answer_i[6:0] == fill_count_i)
    else $error("error answer does not match fill count");

  // fill count never exceeds capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> 32'(fill_count_i) <= 32'(DEPTH))
    else $error("fill count above capacity");

endmodule

bind ordered_array_store oas_checker #(
  .DEPTH(DEPTH)
) u_oas_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_i       (done_o),
  .status_i     (status_o),
  .answer_i     (answer_o),
  .fill_count_i (fill_count_o)
);
